[hdl/crcpfr_pkg.sv]
// Shared types, constants and the CRC-16/MODBUS byte update for the frame receiver.
`timescale 1ns / 1ps

package crcpfr_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] StartMarkerReset = 8'hAA;
  localparam logic [7:0] EndMarkerReset   = 8'hBB;

  // Configuration register indexes.
  localparam logic CfgStartMarker = 1'b0;
  localparam logic CfgEndMarker   = 1'b1;

  typedef enum logic [2:0] {
    PhHunt  = 3'd0,
    PhType  = 3'd1,
    PhLenLo = 3'd2,
    PhLenHi = 3'd3,
    PhData  = 3'd4,
    PhCrcLo = 3'd5,
    PhCrcHi = 3'd6,
    PhEnd   = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    EvNone  = 3'd0,
    EvStart = 3'd1,
    EvCrc   = 3'd2,
    EvEnd   = 3'd3,
    EvDone  = 3'd4
  } event_e;

  typedef struct packed {
    logic        payload_valid;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    event_e      event_res;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
  } result_t;

  // One byte of CRC-16/MODBUS: xor the byte in, then eight reflected shift steps.
  function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                  input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hdl/crcpfr_core.sv]
// Frame parser state machine with running CRC; produces one result per accepted byte.
`timescale 1ns / 1ps

module crcpfr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [7:0]          start_marker_i,
  input  logic [7:0]          end_marker_i,
  output crcpfr_pkg::result_t result_o
);

  crcpfr_pkg::phase_e phase_q, phase_d;
  logic [15:0] byte_count_q, byte_count_d;
  logic [15:0] length_q, length_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_prev_q, crc_prev_d;
  logic [7:0]  crc_lo_q, crc_lo_d;

  logic [15:0] crc_absorb;
  logic [15:0] crc_first;
  logic [15:0] count_inc;
  logic [15:0] crc_got;
  logic [15:0] crc_expect;

  assign crc_absorb = crcpfr_pkg::crc_byte_update(crc_q, rx_byte_i);
  assign crc_first  = crcpfr_pkg::crc_byte_update(crcpfr_pkg::CrcInit, rx_byte_i);
  assign count_inc  = byte_count_q + 16'd1;
  assign crc_got    = {rx_byte_i, crc_lo_q};
  // With a type of zero the last byte before the CRC is not covered.
  assign crc_expect = (type_q == 8'h00) ? crc_prev_q : crc_q;

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    length_d     = length_q;
    type_d       = type_q;
    crc_d        = crc_q;
    crc_prev_d   = crc_prev_q;
    crc_lo_d     = crc_lo_q;
    if (accept_i) begin
      unique case (phase_q)
        crcpfr_pkg::PhHunt: begin
          if (rx_byte_i == start_marker_i) begin
            crc_prev_d   = crcpfr_pkg::CrcInit;
            crc_d        = crc_first;
            type_d       = 8'h00;
            length_d     = 16'h0000;
            byte_count_d = 16'h0000;
            phase_d      = crcpfr_pkg::PhType;
          end
        end
        crcpfr_pkg::PhType: begin
          type_d     = rx_byte_i;
          crc_prev_d = crc_q;
          crc_d      = crc_absorb;
          phase_d    = crcpfr_pkg::PhLenLo;
        end
        crcpfr_pkg::PhLenLo: begin
          length_d   = {8'h00, rx_byte_i};
          crc_prev_d = crc_q;
          crc_d      = crc_absorb;
          phase_d    = crcpfr_pkg::PhLenHi;
        end
        crcpfr_pkg::PhLenHi: begin
          length_d     = {rx_byte_i, length_q[7:0]};
          crc_prev_d   = crc_q;
          crc_d        = crc_absorb;
          byte_count_d = 16'h0000;
          phase_d      = ({rx_byte_i, length_q[7:0]} == 16'h0000) ?
                         crcpfr_pkg::PhCrcLo : crcpfr_pkg::PhData;
        end
        crcpfr_pkg::PhData: begin
          crc_prev_d   = crc_q;
          crc_d        = crc_absorb;
          byte_count_d = count_inc;
          if (count_inc == length_q) begin
            phase_d = crcpfr_pkg::PhCrcLo;
          end
        end
        crcpfr_pkg::PhCrcLo: begin
          crc_lo_d = rx_byte_i;
          phase_d  = crcpfr_pkg::PhCrcHi;
        end
        crcpfr_pkg::PhCrcHi: begin
          phase_d = (crc_got == crc_expect) ? crcpfr_pkg::PhEnd : crcpfr_pkg::PhHunt;
        end
        crcpfr_pkg::PhEnd: begin
          phase_d = crcpfr_pkg::PhHunt;
        end
        default: begin
          phase_d = crcpfr_pkg::PhHunt;
        end
      endcase
    end
  end

  // Result of the current byte.
  always_comb begin
    result_o               = '0;
    result_o.event_res     = crcpfr_pkg::EvNone;
    result_o.frame_type    = type_d;
    result_o.frame_length  = length_d;
    unique case (phase_q)
      crcpfr_pkg::PhHunt: begin
        if (rx_byte_i != start_marker_i) begin
          result_o.event_res = crcpfr_pkg::EvStart;
        end
      end
      crcpfr_pkg::PhData: begin
        result_o.payload_valid = 1'b1;
        result_o.payload_index = byte_count_q;
        result_o.payload_byte  = rx_byte_i;
      end
      crcpfr_pkg::PhCrcHi: begin
        if (crc_got != crc_expect) begin
          result_o.event_res = crcpfr_pkg::EvCrc;
        end
      end
      crcpfr_pkg::PhEnd: begin
        result_o.event_res = (rx_byte_i == end_marker_i) ?
                             crcpfr_pkg::EvDone : crcpfr_pkg::EvEnd;
      end
      default: begin
        result_o.event_res = crcpfr_pkg::EvNone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= crcpfr_pkg::PhHunt;
      byte_count_q <= 16'h0000;
      length_q     <= 16'h0000;
      type_q       <= 8'h00;
      crc_q        <= crcpfr_pkg::CrcInit;
      crc_prev_q   <= crcpfr_pkg::CrcInit;
      crc_lo_q     <= 8'h00;
    end else begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      length_q     <= length_d;
      type_q       <= type_d;
      crc_q        <= crc_d;
      crc_prev_q   <= crc_prev_d;
      crc_lo_q     <= crc_lo_d;
    end
  end

endmodule

[hdl/crcpfr_outbuf.sv]
// Output register with a skid stage so the input side never waits on a combinational stall.
`timescale 1ns / 1ps

module crcpfr_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  crcpfr_pkg::result_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output crcpfr_pkg::result_t out_data_o
);

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  crcpfr_pkg::result_t out_q, out_d;
  crcpfr_pkg::result_t skid_q, skid_d;
  logic                in_take;
  logic                out_take;

  assign in_stall_o  = skid_valid_q;
  assign in_take     = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (in_take) begin
      if (out_valid_q && !out_take) begin
        skid_d       = in_data_i;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = in_data_i;
        out_valid_d = 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

[hdl/crc16_packet_frame_receiver.sv]
// Top level of the framed packet receiver with CRC-16/MODBUS check.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid_i/in_stall_o  rx_byte_i
//   output   out        out_valid_o/out_stall_i payload_*, event_res_o, frame_type_o,
//                                              frame_length_o
//   config   in         cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
// Every accepted byte yields exactly one result beat, at the earliest in the next cycle.
// A byte is accepted in every cycle without an input stall: the CRC byte update and the
// phase step are one level of logic between the parser state registers and the output register.
// The output register is backed by a skid stage, so in_stall_o is registered and only
// rises after the output side has stalled with a beat already held.
// Reset is asynchronous and active low; the parser returns to hunting for a start
// marker and the markers return to their default values.
`timescale 1ns / 1ps

module crc16_packet_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Received byte stream.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // Result stream.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        payload_valid_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  event_res_o,
  output logic [7:0]  frame_type_o,
  output logic [15:0] frame_length_o,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0]          start_marker_q;
  logic [7:0]          end_marker_q;
  logic                in_accept;
  crcpfr_pkg::result_t core_result;
  crcpfr_pkg::result_t out_result;

  // The markers may be rewritten at any time; the new value is used from the next
  // byte onward.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= crcpfr_pkg::StartMarkerReset;
      end_marker_q   <= crcpfr_pkg::EndMarkerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        crcpfr_pkg::CfgStartMarker: start_marker_q <= cfg_data_i;
        crcpfr_pkg::CfgEndMarker:   end_marker_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A beat is taken whenever the skid stage is free.
  assign in_accept = in_valid_i && !in_stall_o;

  // The parser advances only on accepted beats, so its result always matches the
  // byte that the buffer captures in the same cycle.
  crcpfr_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .rx_byte_i      (rx_byte_i),
    .start_marker_i (start_marker_q),
    .end_marker_i   (end_marker_q),
    .result_o       (core_result)
  );

  crcpfr_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (core_result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_result)
  );

  assign payload_valid_o = out_result.payload_valid;
  assign payload_index_o = out_result.payload_index;
  assign payload_byte_o  = out_result.payload_byte;
  assign event_res_o     = out_result.event_res;
  assign frame_type_o    = out_result.frame_type;
  assign frame_length_o  = out_result.frame_length;

endmodule

[hdl/crcpfr_checker.sv]
// Port-level checks for the frame receiver, bound to the top level.
`timescale 1ns / 1ps

module crcpfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        payload_valid_o,
  input logic [15:0] payload_index_o,
  input logic [7:0]  payload_byte_o,
  input logic [2:0]  event_res_o,
  input logic [7:0]  frame_type_o,
  input logic [15:0] frame_length_o,
  input logic        cfg_we_i,
  input logic        cfg_index_i,
  input logic [7:0]  cfg_data_i
);

  // A held beat is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A payload beat never carries a frame event.
  a_payload_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o |-> event_res_o == crcpfr_pkg::EvNone)
    else $error("payload beat carries an event");

  // Outside the payload the index and byte fields read as zero.
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> payload_index_o == 16'd0 && payload_byte_o == 8'd0)
    else $error("payload fields set on a non-payload beat");

  // The input side stalls only while a result is held back by the output side.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && $past(out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A payload index always stays below the frame length.
  a_index_in_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o |-> payload_index_o < frame_length_o)
    else $error("payload index beyond the frame length");

endmodule

bind crc16_packet_frame_receiver crcpfr_checker u_crcpfr_checker (.*);

[verif/crc16_packet_frame_receiver_tb.sv]
// Self-checking testbench for the CRC-16/MODBUS framed packet receiver.
`timescale 1ns / 1ps

module crc16_packet_frame_receiver_tb;

  // Ways in which a generated frame can be damaged on purpose.
  typedef enum int {
    FaultNone,
    FaultCrc,
    FaultCrcHiStart,
    FaultEnd,
    FaultTruncate
  } frame_fault_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        payload_valid_o;
  logic [15:0] payload_index_o;
  logic [7:0]  payload_byte_o;
  logic [2:0]  event_res_o;
  logic [7:0]  frame_type_o;
  logic [15:0] frame_length_o;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;

  crc16_packet_frame_receiver DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .payload_valid_o (payload_valid_o),
    .payload_index_o (payload_index_o),
    .payload_byte_o  (payload_byte_o),
    .event_res_o     (event_res_o),
    .frame_type_o    (frame_type_o),
    .frame_length_o  (frame_length_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Parser state mirrored by the testbench. It is advanced once per accepted
  // input beat, so it always describes the block after its last accepted byte.
  logic [7:0]          start_mk;
  logic [7:0]          end_mk;
  crcpfr_pkg::phase_e  ph;
  logic [15:0]         data_count;
  logic [15:0]         frame_len;
  logic [7:0]          frame_kind;
  logic [15:0]         crc_acc;
  logic [15:0]         crc_prev;
  logic [7:0]          crc_lo_seen;

  // Results still owed by the block, oldest first.
  crcpfr_pkg::result_t pending_results[$];
  // Bytes of the frame currently being built.
  logic [7:0]          frame_q[$];

  int          errors;
  int          bytes_sent;
  // While set, the sender or the result sink never idles.
  bit          tx_calm;
  bit          rx_calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit: a correct run with the longest gaps and stalls on every beat
  // stays well below a tenth of this.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // One byte of CRC-16/MODBUS, one data bit at a time: the feedback bit is the
  // low CRC bit xored with the next data bit, least significant bit first.
  function automatic logic [15:0] modbus_crc_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) begin
        r = r ^ crcpfr_pkg::CrcPoly;
      end
    end
    return r;
  endfunction

  function automatic void crc_absorb(logic [7:0] b);
    crc_prev = crc_acc;
    crc_acc = modbus_crc_step(crc_acc, b);
  endfunction

  function automatic void parser_reset();
    start_mk    = crcpfr_pkg::StartMarkerReset;
    end_mk      = crcpfr_pkg::EndMarkerReset;
    ph          = crcpfr_pkg::PhHunt;
    data_count  = '0;
    frame_len   = '0;
    frame_kind  = '0;
    crc_acc     = crcpfr_pkg::CrcInit;
    crc_prev    = crcpfr_pkg::CrcInit;
    crc_lo_seen = '0;
  endfunction

  // Works out the result beat that one received byte must produce.
  function automatic crcpfr_pkg::result_t frame_rx_predict(logic [7:0] b);
    crcpfr_pkg::result_t r;
    logic [15:0]         rx_crc;
    logic [15:0]         want_crc;
    r = '0;
    r.event_res = crcpfr_pkg::EvNone;
    case (ph)
      crcpfr_pkg::PhHunt: begin
        if (b != start_mk) begin
          r.event_res = crcpfr_pkg::EvStart;
        end else begin
          crc_acc = crcpfr_pkg::CrcInit;
          crc_absorb(b);
          frame_kind = '0;
          frame_len = '0;
          data_count = '0;
          ph = crcpfr_pkg::PhType;
        end
      end
      crcpfr_pkg::PhType: begin
        frame_kind = b;
        crc_absorb(b);
        ph = crcpfr_pkg::PhLenLo;
      end
      crcpfr_pkg::PhLenLo: begin
        frame_len = {8'h00, b};
        crc_absorb(b);
        ph = crcpfr_pkg::PhLenHi;
      end
      crcpfr_pkg::PhLenHi: begin
        frame_len[15:8] = b;
        crc_absorb(b);
        data_count = '0;
        ph = (frame_len == 16'd0) ? crcpfr_pkg::PhCrcLo : crcpfr_pkg::PhData;
      end
      crcpfr_pkg::PhData: begin
        r.payload_valid = 1'b1;
        r.payload_index = data_count;
        r.payload_byte = b;
        crc_absorb(b);
        data_count = data_count + 16'd1;
        if (data_count == frame_len) begin
          ph = crcpfr_pkg::PhCrcLo;
        end
      end
      crcpfr_pkg::PhCrcLo: begin
        crc_lo_seen = b;
        ph = crcpfr_pkg::PhCrcHi;
      end
      crcpfr_pkg::PhCrcHi: begin
        rx_crc = {b, crc_lo_seen};
        // A type-zero frame leaves its last byte before the CRC out of the sum.
        want_crc = (frame_kind == 8'h00) ? crc_prev : crc_acc;
        if (rx_crc == want_crc) begin
          ph = crcpfr_pkg::PhEnd;
        end else begin
          r.event_res = crcpfr_pkg::EvCrc;
          ph = crcpfr_pkg::PhHunt;
        end
      end
      default: begin
        r.event_res = (b == end_mk) ? crcpfr_pkg::EvDone : crcpfr_pkg::EvEnd;
        ph = crcpfr_pkg::PhHunt;
      end
    endcase
    r.frame_type = frame_kind;
    r.frame_length = frame_len;
    return r;
  endfunction

  // Sends one byte: an optional idle gap, then valid with the byte until the
  // beat is taken. Valid stays high on return so back-to-back beats need no
  // second assignment in the same time step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(frame_rx_predict(b));
    bytes_sent++;
  endtask

  // Stops sending and waits until every owed result beat has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Register writes happen only with the result stream empty.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == crcpfr_pkg::CfgStartMarker) begin
      start_mk = value;
    end else begin
      end_mk = value;
    end
  endtask

  // Builds a complete frame with random payload into frame_q, using the
  // marker values the block currently holds, then applies the chosen damage.
  function automatic void build_frame(logic [7:0] kind, int len, frame_fault_e fault);
    logic [15:0] acc;
    logic [15:0] prev;
    logic [15:0] good;
    logic [7:0]  lo;
    logic [7:0]  hi;
    int          keep;
    frame_q.delete();
    frame_q.push_back(start_mk);
    frame_q.push_back(kind);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(len[15:8]);
    for (int i = 0; i < len; i++) begin
      frame_q.push_back(8'($urandom));
    end
    acc = crcpfr_pkg::CrcInit;
    prev = crcpfr_pkg::CrcInit;
    foreach (frame_q[i]) begin
      prev = acc;
      acc = modbus_crc_step(acc, frame_q[i]);
    end
    good = (kind == 8'h00) ? prev : acc;
    if (fault == FaultCrc) begin
      good = good ^ (16'h0001 << $urandom_range(0, 15));
    end
    lo = good[7:0];
    hi = good[15:8];
    // A wrong CRC whose high byte looks like a start marker must not open a frame.
    if (fault == FaultCrcHiStart) begin
      lo = lo ^ 8'h01;
      hi = start_mk;
    end
    frame_q.push_back(lo);
    frame_q.push_back(hi);
    frame_q.push_back((fault == FaultEnd) ? (end_mk ^ 8'($urandom_range(1, 255))) : end_mk);
    // The cut comes after the length bytes, so the parser resynchronizes
    // within a known payload length.
    if (fault == FaultTruncate) begin
      keep = $urandom_range(4, frame_q.size() - 1);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end
  endfunction

  // Sends frame_q, holding back the last hold_back bytes.
  task automatic send_frame_q(input int hold_back);
    for (int i = 0; i < frame_q.size() - hold_back; i++) begin
      send_byte(frame_q[i]);
    end
  endtask

  task automatic send_frame(input logic [7:0] kind, input int len, input frame_fault_e fault);
    build_frame(kind, len, fault);
    send_frame_q(0);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result sink: takes each beat, checks it against the oldest owed result and
  // then draws how many cycles to stall before the next one.
  initial begin
    int                  stall_left;
    crcpfr_pkg::result_t want;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual event %0h",
                   $time, event_res_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("payload_valid", 16'(want.payload_valid), 16'(payload_valid_o));
          check_field("payload_index", want.payload_index, payload_index_o);
          check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte_o));
          check_field("event_res", 16'(want.event_res), 16'(event_res_o));
          check_field("frame_type", 16'(want.frame_type), 16'(frame_type_o));
          check_field("frame_length", want.frame_length, frame_length_o);
        end
        stall_left = rx_calm ? 0 : $urandom_range(0, 4);
      end
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  // While hunting, anything but the start marker is a start error; the two
  // byte extremes are included.
  task automatic test_hunting_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAB);
  endtask

  // Well-formed frames: empty frames of both CRC kinds (with type zero the
  // length high byte is the one left out), short payloads, extreme type bytes.
  task automatic test_clean_frames();
    send_frame(8'h01, 0, FaultNone);
    send_frame(8'h00, 0, FaultNone);
    build_frame(8'h00, 2, FaultNone);
    frame_q[4] = 8'h00;
    frame_q[5] = 8'hFF;
    // The CRC bytes were computed from the random payload, so rebuild them.
    begin
      logic [15:0] acc;
      logic [15:0] prev;
      acc = crcpfr_pkg::CrcInit;
      prev = crcpfr_pkg::CrcInit;
      for (int i = 0; i < 6; i++) begin
        prev = acc;
        acc = modbus_crc_step(acc, frame_q[i]);
      end
      frame_q[6] = prev[7:0];
      frame_q[7] = prev[15:8];
    end
    send_frame_q(0);
    send_frame(8'hFF, 1, FaultNone);
  endtask

  // CRC mismatches send the parser back to hunting, even when the CRC high
  // byte equals the start marker.
  task automatic test_crc_errors();
    send_frame(8'h07, 3, FaultCrc);
    send_frame(8'h00, 1, FaultCrc);
    send_frame(8'h22, 2, FaultCrcHiStart);
    // The sender holds off here until the sink has taken every beat.
    drain();
    send_frame(8'h00, 0, FaultCrcHiStart);
  endtask

  task automatic test_end_errors();
    send_frame(8'h33, 2, FaultEnd);
    send_frame(8'h00, 4, FaultEnd);
    send_frame(8'h10, 1, FaultTruncate);
    send_frame(8'h11, 2, FaultNone);
  endtask

  // Marker registers at their extremes, equal markers, and a change of the end
  // marker while a frame is waiting for its last byte.
  task automatic test_marker_settings();
    write_reg(crcpfr_pkg::CfgStartMarker, 8'h00);
    write_reg(crcpfr_pkg::CfgEndMarker, 8'hFF);
    send_byte(8'h01);
    send_frame(8'h05, 2, FaultNone);
    write_reg(crcpfr_pkg::CfgStartMarker, 8'hFF);
    write_reg(crcpfr_pkg::CfgEndMarker, 8'h00);
    send_frame(8'h00, 3, FaultNone);
    send_byte(8'h00);
    write_reg(crcpfr_pkg::CfgStartMarker, 8'h5A);
    write_reg(crcpfr_pkg::CfgEndMarker, 8'h5A);
    send_frame(8'h44, 1, FaultNone);
    build_frame(8'h12, 3, FaultNone);
    send_frame_q(1);
    write_reg(crcpfr_pkg::CfgEndMarker, 8'h3C);
    send_byte(8'h3C);
    build_frame(8'h13, 1, FaultNone);
    send_frame_q(1);
    write_reg(crcpfr_pkg::CfgEndMarker, 8'hC3);
    send_byte(8'h3C);
    write_reg(crcpfr_pkg::CfgStartMarker, crcpfr_pkg::StartMarkerReset);
    write_reg(crcpfr_pkg::CfgEndMarker, crcpfr_pkg::EndMarkerReset);
  endtask

  // One frame whose length has both bytes nonzero, sent and taken without any
  // idling on either side.
  task automatic test_long_frame();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    send_frame(8'h00, 259, FaultNone);
    drain();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Mostly well-formed frames with random content, mixed with damaged frames,
  // line noise, marker changes and stretches without any idling. Runs until
  // the whole regression has sent its share of bytes.
  task automatic test_random_traffic();
    int           pick;
    int           len;
    logic [7:0]   kind;
    logic [7:0]   value;
    frame_fault_e fault;
    while (bytes_sent < 1100) begin
      if ($urandom_range(0, 15) == 0) tx_calm = ~tx_calm;
      if ($urandom_range(0, 15) == 0) rx_calm = ~rx_calm;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        case ($urandom_range(0, 3))
          0: value = 8'h00;
          1: value = 8'hFF;
          default: value = 8'($urandom);
        endcase
        write_reg(($urandom_range(0, 1) == 0) ? crcpfr_pkg::CfgStartMarker :
                                                crcpfr_pkg::CfgEndMarker, value);
      end else if (pick < 7) begin
        drain();
      end else if (pick < 15) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        kind = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(17, 300) : $urandom_range(0, 16);
        pick = $urandom_range(0, 99);
        if (pick < 70) fault = FaultNone;
        else if (pick < 78) fault = FaultCrc;
        else if (pick < 82) fault = FaultCrcHiStart;
        else if (pick < 90) fault = FaultEnd;
        else fault = FaultTruncate;
        send_frame(kind, len, fault);
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Main sequence: reset once, run each test in turn, then wait for the last
  // beat and report.
  initial begin
    errors = 0;
    bytes_sent = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    parser_reset();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i <= 8'h00;
    cfg_we_i <= 1'b0;
    cfg_index_i <= crcpfr_pkg::CfgStartMarker;
    cfg_data_i <= 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hunting_noise();
    test_clean_frames();
    test_crc_errors();
    test_end_errors();
    test_marker_settings();
    test_long_frame();
    test_random_traffic();

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
